// ----- rtl/core/planar_tile_background_renderer_unit_macros.svh -----
// Assertion macros for the background renderer.
`ifndef PLANAR_TILE_BACKGROUND_RENDERER_UNIT_MACROS_SVH
`define PLANAR_TILE_BACKGROUND_RENDERER_UNIT_MACROS_SVH
`ifndef SYNTH
`define PTBR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTBR_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTBR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define PTBR_ASSERT(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/ptbr_pkg.sv -----
package ptbr_pkg;

    localparam int OPCODE_W      = 2;
    localparam int ADDRESS_W     = 15;
    localparam int WDATA_W       = 16;
    localparam int SCREEN_X_W    = 9;
    localparam int SCREEN_LINE_W = 8;
    localparam int COLOR_W       = 8;

    localparam int VIDEO_WORDS_DEF = 32768;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int MAP_ADDR_W = 13;
    localparam int TILE_W     = 11;

    typedef logic [OPCODE_W-1:0]  t_opcode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_opcode OP_VRAM_WR = 2'd0;
    localparam t_opcode OP_PAL_WR  = 2'd1;
    localparam t_opcode OP_RENDER  = 2'd2;

    localparam t_cfg_idx CFG_SCROLL_X   = 2'd0;
    localparam t_cfg_idx CFG_SCROLL_Y   = 2'd1;
    localparam t_cfg_idx CFG_MAP_WIDTH  = 2'd2;
    localparam t_cfg_idx CFG_MAP_HEIGHT = 2'd3;

    // Map word address: tile column in the low bits, row above, packed by map width.
    function automatic logic [MAP_ADDR_W-1:0] map_addr(
        input logic [6:0] tx,
        input logic [5:0] ty,
        input logic [1:0] wsel,
        input logic       hsel
    );
        logic [5:0]            tym;
        logic [MAP_ADDR_W-1:0] a;
        tym = hsel ? ty : {1'b0, ty[4:0]};
        unique case (wsel)
            2'd0:    a = {2'b00, tym, tx[4:0]};
            2'd1:    a = {1'b0, tym, tx[5:0]};
            default: a = {tym, tx};
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/core/ptbr_if.sv -----
interface ptbr_in_if;
    import ptbr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [ADDRESS_W-1:0]     address;
    logic [WDATA_W-1:0]       write_data;
    logic [SCREEN_X_W-1:0]    screen_x;
    logic [SCREEN_LINE_W-1:0] screen_line;
    modport source (output valid, opcode, address, write_data, screen_x, screen_line,
                    input ready);
    modport sink   (input valid, opcode, address, write_data, screen_x, screen_line,
                    output ready);
endinterface

interface ptbr_out_if;
    import ptbr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     opaque;
    logic [SCREEN_X_W-1:0]    out_x;
    logic [SCREEN_LINE_W-1:0] out_line;
    modport source (output valid, pixel_color, opaque, out_x, out_line, input ready);
    modport sink   (input valid, pixel_color, opaque, out_x, out_line, output ready);
endinterface

interface ptbr_cfg_if;
    import ptbr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/ptbr_ram.sv -----
module ptbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/planar_tile_background_renderer_unit.sv -----
// Background tile pixel generator.
// Channels: i_in_ch takes items (video word write, palette byte write, render
// pixel); o_out_ch gives one pixel per render item; i_cfg_ch writes the scroll
// and map size registers and is always ready.
// Pipeline of four stages: map word read, tile plane reads, palette read,
// output, passed in that order. One item per cycle is accepted while the
// receiver does not stall; the rate is set by the single read port of
// each memory copy, one copy per stage that reads it.
// Writes land in each memory copy as the item passes the stage that reads that
// copy, so every render sees exactly the writes that were accepted before it.
// VIDEO_WORDS must be a power of two; the tile copy is split into two banks by
// address bit 3, which holds plane rows 0-7 and 8-15 apart.
// Reset (synchronous, active low) empties the pipeline and clears the
// configuration registers; memory contents stay undefined until written.
// When the receiver stalls, stages fill up behind the output and ready drops
// only once the first stage cannot move on.
`include "planar_tile_background_renderer_unit_macros.svh"
module planar_tile_background_renderer_unit #(
    parameter int VIDEO_WORDS = ptbr_pkg::VIDEO_WORDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptbr_in_if.sink       i_in_ch,
    ptbr_cfg_if.sink      i_cfg_ch,
    ptbr_out_if.source    o_out_ch
);
    import ptbr_pkg::*;

    localparam int AW = $clog2(VIDEO_WORDS);
    localparam int BW = AW - 1;

    // configuration
    logic [9:0] r_scroll_x;
    logic [8:0] r_scroll_y;
    logic [1:0] r_map_wsel;
    logic       r_map_hsel;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_map_wsel <= '0;
            r_map_hsel <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.reg_index)
                CFG_SCROLL_X:   r_scroll_x <= i_cfg_ch.wdata[9:0];
                CFG_SCROLL_Y:   r_scroll_y <= i_cfg_ch.wdata[8:0];
                CFG_MAP_WIDTH:  r_map_wsel <= i_cfg_ch.wdata[1:0];
                CFG_MAP_HEIGHT: r_map_hsel <= i_cfg_ch.wdata[0];
            endcase
        end
    end

    // stage enables
    logic en_a, en_b, en_c, en_d;
    logic r_a_v, r_b_v, r_c_v, r_d_v;

    assign en_d = !r_d_v || o_out_ch.ready;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;
    assign i_in_ch.ready = en_a;

    // stage A: scroll and map address
    logic [9:0]            n_px;
    logic [8:0]            n_py;
    logic                  n_a_v;
    t_opcode               r_a_op;
    logic [ADDRESS_W-1:0]  r_a_addr;
    logic [WDATA_W-1:0]    r_a_data;
    logic [SCREEN_X_W-1:0] r_a_sx;
    logic [SCREEN_LINE_W-1:0] r_a_sl;
    logic [MAP_ADDR_W-1:0] r_a_map;
    logic [2:0]            r_a_row;
    logic [2:0]            r_a_pbit;

    assign n_px  = 10'(i_in_ch.screen_x) + r_scroll_x;
    assign n_py  = 9'(i_in_ch.screen_line) + r_scroll_y;
    assign n_a_v = i_in_ch.valid && (i_in_ch.opcode == OP_VRAM_WR
                   || i_in_ch.opcode == OP_PAL_WR || i_in_ch.opcode == OP_RENDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= n_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_op   <= i_in_ch.opcode;
            r_a_addr <= i_in_ch.address;
            r_a_data <= i_in_ch.write_data;
            r_a_sx   <= i_in_ch.screen_x;
            r_a_sl   <= i_in_ch.screen_line;
            r_a_map  <= map_addr(n_px[9:3], n_py[8:3], r_map_wsel, r_map_hsel);
            r_a_row  <= n_py[2:0];
            r_a_pbit <= n_px[2:0];
        end
    end

    // map copy of video memory, read and written from stage A
    logic [WDATA_W-1:0] map_q;

    ptbr_ram #(.WIDTH(WDATA_W), .DEPTH(VIDEO_WORDS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (r_a_v && en_b && r_a_op == OP_VRAM_WR),
        .i_waddr (r_a_addr[AW-1:0]),
        .i_wdata (r_a_data),
        .i_re    (en_b),
        .i_raddr (AW'(r_a_map)),
        .o_rdata (map_q)
    );

    // stage B: tile plane reads
    t_opcode               r_b_op;
    logic [ADDRESS_W-1:0]  r_b_addr;
    logic [WDATA_W-1:0]    r_b_data;
    logic [SCREEN_X_W-1:0] r_b_sx;
    logic [SCREEN_LINE_W-1:0] r_b_sl;
    logic [2:0]            r_b_row;
    logic [2:0]            r_b_pbit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_op   <= r_a_op;
            r_b_addr <= r_a_addr;
            r_b_data <= r_a_data;
            r_b_sx   <= r_a_sx;
            r_b_sl   <= r_a_sl;
            r_b_row  <= r_a_row;
            r_b_pbit <= r_a_pbit;
        end
    end

    // bank address drops bit 3 of the word address
    logic [TILE_W+2:0] tile_raddr;
    logic [TILE_W+2:0] tile_waddr;
    logic              tile_we;
    logic [WDATA_W-1:0] w0_q, w1_q;

    assign tile_raddr = {map_q[TILE_W-1:0], r_b_row};
    assign tile_waddr = {r_b_addr[14:4], r_b_addr[2:0]};
    assign tile_we    = r_b_v && en_c && r_b_op == OP_VRAM_WR;

    ptbr_ram #(.WIDTH(WDATA_W), .DEPTH(VIDEO_WORDS / 2)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (tile_we && !r_b_addr[3]),
        .i_waddr (tile_waddr[BW-1:0]),
        .i_wdata (r_b_data),
        .i_re    (en_c),
        .i_raddr (tile_raddr[BW-1:0]),
        .o_rdata (w0_q)
    );

    ptbr_ram #(.WIDTH(WDATA_W), .DEPTH(VIDEO_WORDS / 2)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (tile_we && r_b_addr[3]),
        .i_waddr (tile_waddr[BW-1:0]),
        .i_wdata (r_b_data),
        .i_re    (en_c),
        .i_raddr (tile_raddr[BW-1:0]),
        .o_rdata (w1_q)
    );

    // stage C: color index and palette read
    t_opcode               r_c_op;
    logic [PAL_AW-1:0]     r_c_addr;
    logic [COLOR_W-1:0]    r_c_data;
    logic [SCREEN_X_W-1:0] r_c_sx;
    logic [SCREEN_LINE_W-1:0] r_c_sl;
    logic [2:0]            r_c_pbit;
    logic [3:0]            r_c_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_op    <= r_b_op;
            r_c_addr  <= r_b_addr[PAL_AW-1:0];
            r_c_data  <= r_b_data[COLOR_W-1:0];
            r_c_sx    <= r_b_sx;
            r_c_sl    <= r_b_sl;
            r_c_pbit  <= r_b_pbit;
            r_c_group <= map_q[15:12];
        end
    end

    // leftmost pixel sits in bit 7
    logic [2:0] bsel;
    logic [3:0] cidx;
    logic [7:0] w0_lo, w0_hi, w1_lo, w1_hi;

    assign bsel  = ~r_c_pbit;
    assign w0_lo = w0_q[7:0];
    assign w0_hi = w0_q[15:8];
    assign w1_lo = w1_q[7:0];
    assign w1_hi = w1_q[15:8];
    assign cidx  = {w1_hi[bsel], w1_lo[bsel], w0_hi[bsel], w0_lo[bsel]};

    logic [COLOR_W-1:0] pal_q;

    ptbr_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (r_c_v && en_d && r_c_op == OP_PAL_WR),
        .i_waddr (r_c_addr),
        .i_wdata (r_c_data),
        .i_re    (en_d),
        .i_raddr ({r_c_group, cidx}),
        .o_rdata (pal_q)
    );

    // stage D: result, render items only
    logic                  r_d_opq;
    logic [SCREEN_X_W-1:0] r_d_sx;
    logic [SCREEN_LINE_W-1:0] r_d_sl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en_d) begin
            r_d_v <= r_c_v && r_c_op == OP_RENDER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_opq <= cidx != 4'd0;
            r_d_sx  <= r_c_sx;
            r_d_sl  <= r_c_sl;
        end
    end

    assign o_out_ch.valid       = r_d_v;
    assign o_out_ch.pixel_color = r_d_opq ? pal_q : '0;
    assign o_out_ch.opaque      = r_d_opq;
    assign o_out_ch.out_x       = r_d_sx;
    assign o_out_ch.out_line    = r_d_sl;

    `PTBR_ASSERT(a_reset_empties, i_clk, !i_rst_n |=> !o_out_ch.valid, "pipe not empty")
    `PTBR_ASSERT_RST(a_b_hold, i_clk, i_rst_n, (r_b_v && !en_c) |=> r_b_v, "tile stage lost item")
    `PTBR_ASSERT_RST(a_c_hold, i_clk, i_rst_n,
        (r_c_v && !en_d) |=> (r_c_v && $stable(r_c_op)), "palette stage lost item")
    `PTBR_ASSERT_RST(a_transp, i_clk, i_rst_n,
        (o_out_ch.valid && !o_out_ch.opaque) |-> (o_out_ch.pixel_color == '0), "bad color")
endmodule

// ----- tb/tb_planar_tile_background_renderer_unit.sv -----
`timescale 1ns / 1ps

module tb_planar_tile_background_renderer_unit;
    import ptbr_pkg::*;

    localparam int VWORDS      = VIDEO_WORDS_DEF;
    localparam int NPHASE      = 6;
    localparam int PHASE_ITEMS = 280;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    // opcode that the block must ignore
    localparam t_opcode OP_NONE = 2'd3;

    typedef struct packed {
        t_opcode                  op;
        logic [ADDRESS_W-1:0]     addr;
        logic [WDATA_W-1:0]       data;
        logic [SCREEN_X_W-1:0]    sx;
        logic [SCREEN_LINE_W-1:0] sl;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0]       color;
        logic                     opaque;
        logic [SCREEN_X_W-1:0]    x;
        logic [SCREEN_LINE_W-1:0] line;
    } t_pixel;

    typedef struct packed {
        t_cmd   cmd;
        logic   chk;
        t_pixel want;
    } t_row;

    // memory addresses a render touches, and the color index it finds
    typedef struct packed {
        logic [ADDRESS_W-1:0] map_a;
        logic [ADDRESS_W-1:0] row0_a;
        logic [ADDRESS_W-1:0] row1_a;
        logic [3:0]           cidx;
        logic [PAL_AW-1:0]    pal_a;
    } t_fetch;

    localparam t_pixel NO_PX = '0;

    // Map word 0 -> tile 1 (bit 11 set, ignored), map word 1 -> tile 0x7FF in
    // palette group 15, map word 1023 -> bottom-right corner of a 32x32 map.
    localparam t_row DIRECTED [20] = '{
        '{'{OP_PAL_WR,  15'h0101, 16'h12AB, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_PAL_WR,  15'h7FFF, 16'hFFFF, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_PAL_WR,  15'h0000, 16'h0000, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_PAL_WR,  15'h0203, 16'h773C, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h0000, 16'h0801, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h0010, 16'h0080, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h0018, 16'h0000, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h0001, 16'hF7FF, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h7FF0, 16'hFFFF, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h7FF8, 16'hFFFF, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h03FF, 16'h0001, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h0017, 16'h0101, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_VRAM_WR, 15'h001F, 16'h0000, 9'd0,   8'd0},   1'b0, NO_PX},
        '{'{OP_RENDER,  15'h0000, 16'h0000, 9'd0,   8'd0},   1'b1,
          '{8'hAB, 1'b1, 9'd0, 8'd0}},
        '{'{OP_RENDER,  15'h0000, 16'h0000, 9'd1,   8'd0},   1'b1,
          '{8'h00, 1'b0, 9'd1, 8'd0}},
        '{'{OP_RENDER,  15'h0000, 16'h0000, 9'd8,   8'd0},   1'b1,
          '{8'hFF, 1'b1, 9'd8, 8'd0}},
        '{'{OP_RENDER,  15'h0000, 16'h0000, 9'd511, 8'd255}, 1'b1,
          '{8'h3C, 1'b1, 9'd511, 8'd255}},
        // ignored opcode aimed at tile 1 row 0: a write here would blank pixel 0
        '{'{OP_NONE,    15'h0010, 16'h0000, 9'h1AA, 8'h55},  1'b0, NO_PX},
        '{'{OP_RENDER,  15'h0000, 16'h0000, 9'd0,   8'd0},   1'b1,
          '{8'hAB, 1'b1, 9'd0, 8'd0}},
        '{'{OP_RENDER,  15'h7FFF, 16'hFFFF, 9'd7,   8'd0},   1'b0, NO_PX}
    };

    logic i_clk;
    logic i_rst_n;

    ptbr_in_if  in_ch();
    ptbr_out_if out_ch();
    ptbr_cfg_if cfg_ch();

    planar_tile_background_renderer_unit #(
        .VIDEO_WORDS(VWORDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .i_cfg_ch(cfg_ch),
        .o_out_ch(out_ch)
    );

    // mirror of the block's state
    bit [WDATA_W-1:0] vram_mirror [VWORDS];
    bit               vram_set    [VWORDS];
    bit [COLOR_W-1:0] pal_mirror  [PALETTE_ENTRIES];
    bit               pal_set     [PALETTE_ENTRIES];
    logic [9:0] scroll_x_r = '0;
    logic [8:0] scroll_y_r = '0;
    logic [1:0] wsel_r     = '0;
    logic       hsel_r     = 1'b0;

    t_pixel pending_px [$];

    int  errors         = 0;
    int  items_sent     = 0;
    int  pixels_checked = 0;
    int  opaque_seen    = 0;
    int  settings_used  = 1;
    int  cycle_cnt      = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    bit  calm_tail      = 1'b0;
    bit  hold_req       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_fetch trace_pixel(input logic [8:0] sx, input logic [7:0] sl);
        int unsigned map_w, map_h, px, py, tx, ty, tile, bitn;
        logic [WDATA_W-1:0] entry, w0, w1;
        t_fetch f;
        map_w = (wsel_r == 2'd0) ? 32 : (wsel_r == 2'd1) ? 64 : 128;
        map_h = hsel_r ? 64 : 32;
        px = sx + scroll_x_r;
        py = sl + scroll_y_r;
        tx = (px >> 3) & (map_w - 1);
        ty = (py >> 3) & (map_h - 1);
        f.map_a = ADDRESS_W'((tx + ty * map_w) % VWORDS);
        entry = vram_mirror[f.map_a];
        tile = entry[10:0];
        f.row0_a = ADDRESS_W'((tile * 16 + (py & 7)) % VWORDS);
        f.row1_a = ADDRESS_W'((tile * 16 + (py & 7) + 8) % VWORDS);
        w0 = vram_mirror[f.row0_a];
        w1 = vram_mirror[f.row1_a];
        // leftmost pixel sits in bit 7 of each plane byte
        bitn = 7 - (px & 7);
        f.cidx = {w1[bitn + 8], w1[bitn], w0[bitn + 8], w0[bitn]};
        f.pal_a = PAL_AW'({entry[15:12], 4'h0} + f.cidx);
        return f;
    endfunction

    function automatic t_pixel shade_pixel(input logic [8:0] sx, input logic [7:0] sl);
        t_fetch f;
        t_pixel p;
        f = trace_pixel(sx, sl);
        p.x = sx;
        p.line = sl;
        p.opaque = (f.cidx != 4'd0);
        p.color = p.opaque ? pal_mirror[f.pal_a] : '0;
        return p;
    endfunction

    function automatic t_cmd rand_cmd(input t_opcode op);
        t_cmd c;
        c.op   = op;
        c.addr = ADDRESS_W'($urandom);
        c.data = WDATA_W'($urandom);
        c.sx   = SCREEN_X_W'($urandom);
        c.sl   = SCREEN_LINE_W'($urandom);
        return c;
    endfunction

    // Gives the write that fills the first entry this render would read unset.
    function automatic bit first_unwritten(input logic [8:0] sx, input logic [7:0] sl,
                                           output t_cmd fix);
        t_fetch f;
        f = trace_pixel(sx, sl);
        fix = rand_cmd(OP_VRAM_WR);
        if (!vram_set[f.map_a]) begin
            fix.addr = f.map_a;
            // half the map words reuse a few tiles so tile data gets shared
            if ($urandom_range(0, 1) == 0)
                fix.data[10:0] = 11'($urandom_range(0, 15));
            return 1'b1;
        end
        if (!vram_set[f.row0_a]) begin
            fix.addr = f.row0_a;
            return 1'b1;
        end
        if (!vram_set[f.row1_a]) begin
            fix.addr = f.row1_a;
            return 1'b1;
        end
        if (f.cidx != 4'd0 && !pal_set[f.pal_a]) begin
            fix.op = OP_PAL_WR;
            fix.addr[PAL_AW-1:0] = f.pal_a;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Called just after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input t_cmd c, input bit chk, input t_pixel want);
        if (tx_idle_on && !calm_tail && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= c.op;
        in_ch.address     <= c.addr;
        in_ch.write_data  <= c.data;
        in_ch.screen_x    <= c.sx;
        in_ch.screen_line <= c.sl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (c.op)
            OP_VRAM_WR: begin
                vram_mirror[int'(c.addr) % VWORDS] = c.data;
                vram_set[int'(c.addr) % VWORDS] = 1'b1;
            end
            OP_PAL_WR: begin
                pal_mirror[c.addr[PAL_AW-1:0]] = c.data[COLOR_W-1:0];
                pal_set[c.addr[PAL_AW-1:0]] = 1'b1;
            end
            OP_RENDER: pending_px.push_back(chk ? want : shade_pixel(c.sx, c.sl));
            default: ;
        endcase
        if (c.op != OP_NONE)
            items_sent++;
    endtask

    task automatic render_at(input logic [8:0] sx, input logic [7:0] sl);
        t_cmd c;
        while (first_unwritten(sx, sl, c))
            send_item(c, 1'b0, NO_PX);
        c = rand_cmd(OP_RENDER);
        c.sx = sx;
        c.sl = sl;
        send_item(c, 1'b0, NO_PX);
    endtask

    // Stop offering items, wait for every pixel, then let the pipe empty.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_SCROLL_X:   scroll_x_r = val[9:0];
            CFG_SCROLL_Y:   scroll_y_r = val[8:0];
            CFG_MAP_WIDTH:  wsel_r     = val[1:0];
            CFG_MAP_HEIGHT: hsel_r     = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [9:0] sx, input logic [8:0] sy,
                            input logic [1:0] ws, input logic hs);
        drain();
        write_reg(CFG_SCROLL_X, sx);
        write_reg(CFG_SCROLL_Y, CFG_DATA_W'(sy));
        write_reg(CFG_MAP_WIDTH, CFG_DATA_W'(ws));
        write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(hs));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (rx_idle_on && !calm_tail && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.color  = out_ch.pixel_color;
            got.opaque = out_ch.opaque;
            got.x      = out_ch.out_x;
            got.line   = out_ch.out_line;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d line=%0d color=%0h",
                         $time, got.x, got.line, got.color);
                errors++;
            end else begin
                want = pending_px.pop_front();
                pixels_checked++;
                if (got.opaque)
                    opaque_seen++;
                if (got.color != want.color) begin
                    $display("%0t: pixel_color expected %0h actual %0h (x=%0d line=%0d)",
                             $time, want.color, got.color, want.x, want.line);
                    errors++;
                end
                if (got.opaque != want.opaque) begin
                    $display("%0t: opaque expected %0d actual %0d (x=%0d line=%0d)",
                             $time, want.opaque, got.opaque, want.x, want.line);
                    errors++;
                end
                if (got.x != want.x) begin
                    $display("%0t: out_x expected %0d actual %0d",
                             $time, want.x, got.x);
                    errors++;
                end
                if (got.line != want.line) begin
                    $display("%0t: out_line expected %0d actual %0d",
                             $time, want.line, got.line);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d pixels still pending", $time, pending_px.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int   start;
        int   r;
        logic [8:0] x0;
        logic [7:0] ln;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= OP_NONE;
        in_ch.address      <= '0;
        in_ch.write_data   <= '0;
        in_ch.screen_x     <= '0;
        in_ch.screen_line  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= CFG_SCROLL_X;
        cfg_ch.wdata       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].cmd, DIRECTED[i].chk, DIRECTED[i].want);

        for (int p = 0; p < NPHASE; p++) begin
            case (p)
                1: set_regs(10'h3FF, 9'h1FF, 2'd3, 1'b1);
                2: set_regs(10'($urandom_range(1, 1022)), 9'($urandom_range(1, 510)),
                            2'd1, 1'b0);
                3: set_regs(10'h000, 9'h1FF, 2'd2, 1'b1);
                4: set_regs(10'h3FF, 9'h000, 2'd0, 1'b1);
                5: set_regs(10'($urandom), 9'($urandom), 2'($urandom), 1'($urandom));
                default: ;
            endcase
            // long output stall while renders keep coming in
            if (p == 2)
                hold_req = 1'b1;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (p == NPHASE - 1 && items_sent - start >= PHASE_ITEMS / 2)
                    calm_tail = 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                end
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    render_at(9'($urandom), 8'($urandom));
                end else if (r < 67) begin
                    send_item(rand_cmd(OP_VRAM_WR), 1'b0, NO_PX);
                end else if (r < 75) begin
                    send_item(rand_cmd(OP_PAL_WR), 1'b0, NO_PX);
                end else if (r < 80) begin
                    send_item(rand_cmd(OP_NONE), 1'b0, NO_PX);
                end else begin
                    // a short run along one line
                    x0 = 9'($urandom);
                    ln = 8'($urandom);
                    for (int k = 0; k < 8; k++)
                        render_at(x0 + 9'(k), ln);
                end
            end
        end

        drain();
        $display("Covered %0d items under %0d register settings, with one long output stall.",
                 items_sent, settings_used);
        $display("Checked %0d pixels: %0d opaque, %0d transparent; %0d mismatches.",
                 pixels_checked, opaque_seen, pixels_checked - opaque_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
